@@ src/recursive_reader_writer_lock_unit_defines.svh @@
// Assertion helpers shared by the lock unit's modules.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef RECURSIVE_READER_WRITER_LOCK_UNIT_DEFINES_SVH
`define RECURSIVE_READER_WRITER_LOCK_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RWL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RWL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/rwl_pkg.sv @@
`timescale 1ns / 1ps
package rwl_pkg;

  typedef enum logic [3:0] {
    FN_ACQ_READ      = 4'd0,
    FN_TRY_READ      = 4'd1,
    FN_RESUME_READ   = 4'd2,
    FN_ABANDON_READ  = 4'd3,
    FN_ACQ_WRITE     = 4'd4,
    FN_TRY_WRITE     = 4'd5,
    FN_RESUME_WRITE  = 4'd6,
    FN_ABANDON_WRITE = 4'd7,
    FN_UNLOCK        = 4'd8
  } rwl_func_t;

  typedef enum logic [2:0] {
    ST_GRANTED   = 3'd0,
    ST_REFUSED   = 3'd1,
    ST_WAIT      = 3'd2,
    ST_RELEASED  = 3'd3,
    ST_HELD      = 3'd4,
    ST_NOTLOCKED = 3'd5,
    ST_FULL      = 3'd6,
    ST_SAT       = 3'd7
  } rwl_status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the request word
    logic commit;  // apply the request to the lock state and register the result
  } rwl_cmd_t;

endpackage

@@ src/rwl_req_if.sv @@
`timescale 1ns / 1ps
interface rwl_req_if #(
  parameter int THREAD_ID_BITS = 8
);
  logic                      valid;
  logic                      ready;
  logic [3:0]                func;
  logic [THREAD_ID_BITS-1:0] thread_id;

  modport source (output valid, func, thread_id, input ready);
  modport sink (input valid, func, thread_id, output ready);
endinterface

@@ src/rwl_rsp_if.sv @@
`timescale 1ns / 1ps
interface rwl_rsp_if #(
  parameter int COUNT_BITS  = 16,
  parameter int WAITER_BITS = 8
);
  logic                          valid;
  logic                          ready;
  logic [2:0]                    status;
  logic                          wake_one_writer;
  logic                          wake_all_readers;
  logic signed [COUNT_BITS-1:0]  lock_count;
  logic [WAITER_BITS-1:0]        readers_waiting;
  logic [WAITER_BITS-1:0]        writers_waiting;

  modport source (output valid, status, wake_one_writer, wake_all_readers, lock_count,
                  readers_waiting, writers_waiting, input ready);
  modport sink (input valid, status, wake_one_writer, wake_all_readers, lock_count,
                readers_waiting, writers_waiting, output ready);
endinterface

@@ src/rwl_cfg_if.sv @@
`timescale 1ns / 1ps
interface rwl_cfg_if;
  logic valid;
  logic ready;
  logic recursive_mode;

  modport source (output valid, recursive_mode, input ready);
  modport sink (input valid, recursive_mode, output ready);
endinterface

@@ src/recursive_reader_writer_lock_unit.sv @@
`timescale 1ns / 1ps
// A word accepted in one cycle is applied to the lock state in the cycle after, in the
// controller's single execute state, and its registered result is offered from then on
// until it is taken; a new word is taken in the cycle the previous result is taken, not
// before. Reset (synchronous, rst_n low) clears the holder count, both waiter counts,
// the reader table valid bits, the write owner, recursive_mode, the result word and the
// controller state.
module recursive_reader_writer_lock_unit import rwl_pkg::*; #(
  parameter int READER_SLOTS   = 16,
  parameter int THREAD_ID_BITS = 8,
  parameter int COUNT_BITS     = 16,
  parameter int WAITER_BITS    = 8
) (
  input logic       clk,
  input logic       rst_n,
  rwl_req_if.sink   in_req,
  rwl_rsp_if.source out_rsp,
  rwl_cfg_if.sink   cfg_wr
);

  rwl_cmd_t cmd;

  assign cfg_wr.ready = 1'b1;

  rwl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .cmd       (cmd)
  );

  rwl_datapath #(
    .READER_SLOTS   (READER_SLOTS),
    .THREAD_ID_BITS (THREAD_ID_BITS),
    .COUNT_BITS     (COUNT_BITS),
    .WAITER_BITS    (WAITER_BITS)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .in_func              (in_req.func),
    .in_thread_id         (in_req.thread_id),
    .cfg_we               (cfg_wr.valid),
    .cfg_mode             (cfg_wr.recursive_mode),
    .out_status           (out_rsp.status),
    .out_wake_one_writer  (out_rsp.wake_one_writer),
    .out_wake_all_readers (out_rsp.wake_all_readers),
    .out_lock_count       (out_rsp.lock_count),
    .out_readers_waiting  (out_rsp.readers_waiting),
    .out_writers_waiting  (out_rsp.writers_waiting)
  );

endmodule

@@ src/rwl_ctrl.sv @@
`timescale 1ns / 1ps
`include "recursive_reader_writer_lock_unit_defines.svh"
module rwl_ctrl import rwl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output rwl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A new word may enter in the same cycle the finished result is taken.
  assign in_ready   = (state_r == S_IDLE) || ((state_r == S_DONE) && out_ready);
  assign out_valid  = (state_r == S_DONE);
  assign cmd.load   = in_valid && in_ready;
  assign cmd.commit = (state_r == S_EXEC);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_ready) state_nxt = in_valid ? S_EXEC : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `RWL_ASSERT_NEXT(a_load_then_exec, cmd.load, state_r == S_EXEC, "accepted word did not start")
  `RWL_ASSERT_NEXT(a_exec_then_done, state_r == S_EXEC, out_valid, "result not presented")
  `RWL_ASSERT_NEXT(a_done_holds, out_valid && !out_ready, state_r == S_DONE,
                   "result dropped before it was taken")

endmodule

@@ src/rwl_datapath.sv @@
`timescale 1ns / 1ps
`include "recursive_reader_writer_lock_unit_defines.svh"
module rwl_datapath import rwl_pkg::*; #(
  parameter int READER_SLOTS   = 16,
  parameter int THREAD_ID_BITS = 8,
  parameter int COUNT_BITS     = 16,
  parameter int WAITER_BITS    = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rwl_cmd_t                     cmd,
  input  logic [3:0]                   in_func,
  input  logic [THREAD_ID_BITS-1:0]    in_thread_id,
  input  logic                         cfg_we,
  input  logic                         cfg_mode,
  output logic [2:0]                   out_status,
  output logic                         out_wake_one_writer,
  output logic                         out_wake_all_readers,
  output logic signed [COUNT_BITS-1:0] out_lock_count,
  output logic [WAITER_BITS-1:0]       out_readers_waiting,
  output logic [WAITER_BITS-1:0]       out_writers_waiting
);

  localparam int SLOT_BITS = $clog2(READER_SLOTS);
  localparam logic signed [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic signed [COUNT_BITS-1:0] CNT_MIN =
    {1'b1, {(COUNT_BITS-2){1'b0}}, 1'b1};
  localparam logic signed [COUNT_BITS-1:0] CNT_ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};
  localparam logic signed [COUNT_BITS-1:0] CNT_NEG_ONE = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] DEPTH_ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};
  localparam logic [WAITER_BITS-1:0] WAIT_MAX = {WAITER_BITS{1'b1}};
  localparam logic [WAITER_BITS-1:0] WAIT_ONE = {{(WAITER_BITS-1){1'b0}}, 1'b1};

  logic [3:0]                   func_r;
  logic [THREAD_ID_BITS-1:0]    tid_r;
  logic                         mode_r;
  logic signed [COUNT_BITS-1:0] hc_r, hc_nxt;
  logic [WAITER_BITS-1:0]       wr_r, wr_nxt;
  logic [WAITER_BITS-1:0]       ww_r, ww_nxt;
  logic [THREAD_ID_BITS-1:0]    own_r, own_nxt;
  logic                         own_v_r, own_v_nxt;
  logic [READER_SLOTS-1:0]      slot_v_r;
  logic [THREAD_ID_BITS-1:0]    slot_t_r [READER_SLOTS];
  logic [COUNT_BITS-1:0]        slot_d_r [READER_SLOTS];

  logic [READER_SLOTS-1:0] hit_vec;
  logic                    hit_any, free_any;
  logic [SLOT_BITS-1:0]    hit_idx, free_idx;

  logic [2:0] st_nxt, rd_st;
  logic       wake_w_nxt, wake_r_nxt;
  logic       rd_sat, rd_full, rd_ok, own_hit;
  logic       do_read, alloc_slot, bump_slot, drop_slot, freed;

  // Request and configuration registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      tid_r  <= in_thread_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_we) begin
      mode_r <= cfg_mode;
    end
  end

  // Parallel match over the reader table; the lowest free slot is taken for a new reader.
  always_comb begin
    for (int i = 0; i < READER_SLOTS; i++) begin
      hit_vec[i] = slot_v_r[i] && (slot_t_r[i] == tid_r);
    end
  end

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = READER_SLOTS - 1; i >= 0; i--) begin
      if (hit_vec[i]) hit_idx = SLOT_BITS'(i);
      if (!slot_v_r[i]) free_idx = SLOT_BITS'(i);
    end
  end

  assign hit_any  = |hit_vec;
  assign free_any = ~&slot_v_r;

  assign rd_sat  = (hc_r == CNT_MAX);
  assign rd_full = mode_r && !hit_any && !free_any;
  assign rd_ok   = !rd_sat && !rd_full;
  assign rd_st   = rd_sat ? ST_SAT : (rd_full ? ST_FULL : ST_GRANTED);
  assign own_hit = mode_r && own_v_r && (own_r == tid_r);

  always_comb begin
    hc_nxt     = hc_r;
    wr_nxt     = wr_r;
    ww_nxt     = ww_r;
    own_nxt    = own_r;
    own_v_nxt  = own_v_r;
    st_nxt     = ST_REFUSED;
    wake_w_nxt = 1'b0;
    wake_r_nxt = 1'b0;
    do_read    = 1'b0;
    alloc_slot = 1'b0;
    bump_slot  = 1'b0;
    drop_slot  = 1'b0;
    freed      = 1'b0;

    case (func_r)
      FN_ACQ_READ, FN_TRY_READ: begin
        if (mode_r && hit_any) begin
          do_read = 1'b1;
        end else if (func_r == FN_TRY_READ) begin
          if (hc_r[COUNT_BITS-1]) st_nxt = ST_REFUSED;
          else do_read = 1'b1;
        end else if (hc_r[COUNT_BITS-1] || (ww_r != '0)) begin
          if (wr_r == WAIT_MAX) begin
            st_nxt = ST_SAT;
          end else begin
            wr_nxt = wr_r + WAIT_ONE;
            st_nxt = ST_WAIT;
          end
        end else begin
          do_read = 1'b1;
        end
      end
      FN_RESUME_READ: begin
        if (wr_r == '0) begin
          st_nxt = ST_REFUSED;
        end else if (hc_r[COUNT_BITS-1] || (ww_r != '0)) begin
          st_nxt = ST_WAIT;
        end else begin
          do_read = 1'b1;
          if (rd_ok) wr_nxt = wr_r - WAIT_ONE;
        end
      end
      FN_ABANDON_READ: begin
        if (wr_r != '0) wr_nxt = wr_r - WAIT_ONE;
        st_nxt = ST_REFUSED;
      end
      FN_ACQ_WRITE, FN_TRY_WRITE: begin
        if (own_hit) begin
          if (hc_r == CNT_MIN) begin
            st_nxt = ST_SAT;
          end else begin
            hc_nxt = hc_r - CNT_ONE;
            st_nxt = ST_GRANTED;
          end
        end else if (hc_r != '0) begin
          if (func_r == FN_TRY_WRITE) begin
            st_nxt = ST_REFUSED;
          end else if (ww_r == WAIT_MAX) begin
            st_nxt = ST_SAT;
          end else begin
            ww_nxt = ww_r + WAIT_ONE;
            st_nxt = ST_WAIT;
          end
        end else begin
          hc_nxt = CNT_NEG_ONE;
          if (mode_r) begin
            own_nxt   = tid_r;
            own_v_nxt = 1'b1;
          end
          st_nxt = ST_GRANTED;
        end
      end
      FN_RESUME_WRITE: begin
        if (ww_r == '0) begin
          st_nxt = ST_REFUSED;
        end else if (hc_r != '0) begin
          st_nxt = ST_WAIT;
        end else begin
          hc_nxt = CNT_NEG_ONE;
          if (mode_r) begin
            own_nxt   = tid_r;
            own_v_nxt = 1'b1;
          end
          ww_nxt = ww_r - WAIT_ONE;
          st_nxt = ST_GRANTED;
        end
      end
      FN_ABANDON_WRITE: begin
        if (ww_r != '0) ww_nxt = ww_r - WAIT_ONE;
        st_nxt = ST_REFUSED;
      end
      FN_UNLOCK: begin
        if (hc_r == '0) begin
          st_nxt = ST_NOTLOCKED;
        end else begin
          if (!hc_r[COUNT_BITS-1]) begin
            drop_slot = mode_r && hit_any;
            hc_nxt    = hc_r - CNT_ONE;
            freed     = (hc_r == CNT_ONE);
          end else begin
            hc_nxt = hc_r + CNT_ONE;
            if (hc_r == CNT_NEG_ONE) begin
              freed     = 1'b1;
              own_v_nxt = 1'b0;
              own_nxt   = '0;
            end
          end
          st_nxt     = freed ? ST_RELEASED : ST_HELD;
          wake_w_nxt = freed && (ww_r != '0);
          wake_r_nxt = freed && (ww_r == '0) && (wr_r != '0);
        end
      end
      default: begin
        st_nxt = ST_REFUSED;
      end
    endcase

    // Shared read grant: in recursive mode, bump the requester's slot or open a new one.
    if (do_read) begin
      st_nxt = rd_st;
      if (rd_ok) begin
        hc_nxt = hc_r + CNT_ONE;
        if (mode_r) begin
          bump_slot  = hit_any;
          alloc_slot = !hit_any;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r    <= '0;
      wr_r    <= '0;
      ww_r    <= '0;
      own_r   <= '0;
      own_v_r <= 1'b0;
    end else if (cmd.commit) begin
      hc_r    <= hc_nxt;
      wr_r    <= wr_nxt;
      ww_r    <= ww_nxt;
      own_r   <= own_nxt;
      own_v_r <= own_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_v_r <= '0;
    end else if (cmd.commit) begin
      if (alloc_slot) slot_v_r[free_idx] <= 1'b1;
      if (drop_slot && (slot_d_r[hit_idx] <= DEPTH_ONE)) slot_v_r[hit_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (alloc_slot) begin
        slot_t_r[free_idx] <= tid_r;
        slot_d_r[free_idx] <= DEPTH_ONE;
      end
      if (bump_slot) slot_d_r[hit_idx] <= slot_d_r[hit_idx] + DEPTH_ONE;
      if (drop_slot) slot_d_r[hit_idx] <= slot_d_r[hit_idx] - DEPTH_ONE;
    end
  end

  // Result word, held until the next request commits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_status           <= ST_GRANTED;
      out_wake_one_writer  <= 1'b0;
      out_wake_all_readers <= 1'b0;
      out_lock_count       <= '0;
      out_readers_waiting  <= '0;
      out_writers_waiting  <= '0;
    end else if (cmd.commit) begin
      out_status           <= st_nxt;
      out_wake_one_writer  <= wake_w_nxt;
      out_wake_all_readers <= wake_r_nxt;
      out_lock_count       <= hc_nxt;
      out_readers_waiting  <= wr_nxt;
      out_writers_waiting  <= ww_nxt;
    end
  end

  `RWL_ASSERT_SAME(a_wake_only_on_release, out_wake_one_writer || out_wake_all_readers,
                   out_status == ST_RELEASED, "wake without release")
  `RWL_ASSERT_SAME(a_wake_writer_waits, out_wake_one_writer, ww_r != '0,
                   "writer woken with none waiting")
  `RWL_ASSERT_SAME(a_wake_readers_only, out_wake_all_readers, (ww_r == '0) && (wr_r != '0),
                   "readers woken while a writer waits or none wait")
  `RWL_ASSERT_NEXT(a_state_holds_idle, !cmd.commit,
                   $stable(hc_r) && $stable(wr_r) && $stable(ww_r),
                   "lock state moved without a commit")

endmodule
